>>> rtl/assert_macros.svh
// Assertion macros shared by the Hermite evaluator RTL.
// No dependencies; pulled in by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define HPE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hpe assertion failed");

// Clocked check that also holds during reset.
`define HPE_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("hpe assertion failed");

`endif

>>> rtl/hpe_pkg.sv
// Shared types and fixed widths for the Hermite polynomial evaluator.
// No dependencies; used by hpe_cell and the top level.
package hpe_pkg;

   localparam int X_WIDTH      = 16;  // sample_x field
   localparam int VALUE_WIDTH  = 64;  // poly_value field
   localparam int HALF_WIDTH   = 32;  // split point of the 64-bit operand
   localparam int DEGREE_WIDTH = 4;   // degree register
   localparam int MULT_WIDTH   = X_WIDTH + 1;        // 2x
   localparam int PART_WIDTH   = HALF_WIDTH + MULT_WIDTH + 1;
   localparam int FACTOR_WIDTH = 8;   // 2(k-1), k up to 20
   localparam int PROD_WIDTH   = VALUE_WIDTH + FACTOR_WIDTH;
   localparam int WIDE_WIDTH   = VALUE_WIDTH + MULT_WIDTH + 1;

   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // Data handed from one cell to the next.
   typedef struct packed {
      logic                          valid;
      logic                          ovf;
      logic signed [X_WIDTH-1:0]     x;
      logic signed [VALUE_WIDTH-1:0] p1;  // h_{k-1}
      logic signed [VALUE_WIDTH-1:0] p2;  // h_{k-2}
   } link_type;

endpackage

>>> rtl/hpe_cell.sv
// One recurrence step h_k = 2x*h_{k-1} - 2(k-1)*h_{k-2}, two register stages.
// Depends on hpe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hpe_cell #(
   parameter int STEP      = 2,
   parameter int FRAC_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [hpe_pkg::DEGREE_WIDTH-1:0] degree,
   input  hpe_pkg::link_type                link_i,
   output hpe_pkg::link_type                link_o
);
   import hpe_pkg::*;

   localparam logic signed [FACTOR_WIDTH-1:0] STEP_FACTOR = FACTOR_WIDTH'(2 * (STEP - 1));

   // stage A: partial products
   logic                          a_valid_ff, a_active_ff, a_ovf_ff;
   logic signed [X_WIDTH-1:0]     a_x_ff;
   logic signed [VALUE_WIDTH-1:0] a_p1_ff, a_p2_ff;
   logic signed [PART_WIDTH-1:0]  a_lo_ff, a_hi_ff;
   logic signed [PROD_WIDTH-1:0]  a_sub_ff;

   logic signed [MULT_WIDTH-1:0]  two_x;
   logic signed [PART_WIDTH-1:0]  a_lo_in, a_hi_in;
   logic signed [PROD_WIDTH-1:0]  a_sub_in;
   logic                          a_active_in;

   // stage B: combine, shift, subtract, saturate
   logic signed [WIDE_WIDTH-1:0]  prod_w, shifted_w, diff_w;
   logic [WIDE_WIDTH-VALUE_WIDTH:0] top_bits;
   logic                          fits;
   logic signed [VALUE_WIDTH-1:0] sat_value;
   link_type                      b_ff, b_in;

   assign two_x       = $signed({link_i.x, 1'b0});
   assign a_lo_in     = PART_WIDTH'($signed({1'b0, link_i.p1[HALF_WIDTH-1:0]}))
                        * PART_WIDTH'(two_x);
   assign a_hi_in     = PART_WIDTH'($signed(link_i.p1[VALUE_WIDTH-1:HALF_WIDTH]))
                        * PART_WIDTH'(two_x);
   assign a_sub_in    = PROD_WIDTH'(link_i.p2) * PROD_WIDTH'(STEP_FACTOR);
   assign a_active_in = (STEP <= int'(degree));

   assign prod_w    = (WIDE_WIDTH'(a_hi_ff) <<< HALF_WIDTH) + WIDE_WIDTH'(a_lo_ff);
   assign shifted_w = prod_w >>> FRAC_BITS;
   assign diff_w    = shifted_w - WIDE_WIDTH'(a_sub_ff);
   assign top_bits  = diff_w[WIDE_WIDTH-1:VALUE_WIDTH-1];
   assign fits      = (&top_bits) | ~(|top_bits);
   assign sat_value = fits ? diff_w[VALUE_WIDTH-1:0]
                           : (diff_w[WIDE_WIDTH-1] ? VALUE_MIN : VALUE_MAX);

   always_comb begin
      b_in.valid = a_valid_ff;
      b_in.x     = a_x_ff;
      if (a_active_ff) begin
         b_in.p1  = sat_value;
         b_in.p2  = a_p1_ff;
         b_in.ovf = a_ovf_ff | ~fits;
      end else begin
         b_in.p1  = a_p1_ff;
         b_in.p2  = a_p2_ff;
         b_in.ovf = a_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_ff.valid <= 1'b0;
      end else if (advance) begin
         a_valid_ff  <= link_i.valid;
         a_active_ff <= a_active_in;
         a_ovf_ff    <= link_i.ovf;
         a_x_ff      <= link_i.x;
         a_p1_ff     <= link_i.p1;
         a_p2_ff     <= link_i.p2;
         a_lo_ff     <= a_lo_in;
         a_hi_ff     <= a_hi_in;
         a_sub_ff    <= a_sub_in;
         b_ff        <= b_in;
      end
   end

   assign link_o = b_ff;

   `HPE_ASSERT(a_pass_through, clock, reset,
      advance && a_valid_ff && !a_active_ff |=>
         link_o.p1 == $past(a_p1_ff) && link_o.p2 == $past(a_p2_ff))
   `HPE_ASSERT(a_sat_limit, clock, reset,
      advance && a_valid_ff && a_active_ff && !fits |=>
         link_o.ovf && (link_o.p1 == VALUE_MAX || link_o.p1 == VALUE_MIN))
   `HPE_ASSERT(a_valid_moves, clock, reset,
      advance |=> link_o.valid == $past(a_valid_ff))

endmodule

>>> rtl/hermite_polynomial_evaluator_unit.sv
// Top level of the Hermite polynomial evaluator: head stage, chain of cells, output register.
// Depends on hpe_pkg, hpe_cell and assert_macros.svh.
//
// Usage:
//  - req_ channel: one sample point x per transfer (signed Q3.12 in req_tdata).
//  - rsp_ channel: one result per request, H_n(x) in rsp_tdata with FRAC_BITS
//    fraction bits, saturated to 64 bits; rsp_tuser flags any saturated step.
//  - csr_ channel: writes the degree n (values above MAX_DEGREE act as MAX_DEGREE).
//    Always ready; write only while no request is in flight.
//  - Pipeline: one head stage, two stages per cell for k = 2..MAX_DEGREE,
//    one output register. Cells past n pass data through.
//  - Throughput: one point per cycle while the output is not stalled, set by the
//    cell chain, which holds one point in each stage.
//  - Stall: when rsp_tvalid is high and rsp_tready low, the whole chain holds
//    and req_tready drops in the same cycle; nothing is lost.
//  - Reset: clears all stage valid bits and the degree register (degree 0).
`include "assert_macros.svh"

module hermite_polynomial_evaluator_unit #(
   parameter int MAX_DEGREE = 12,
   parameter int FRAC_BITS  = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // [15:0] sample_x
   // response
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [63:0]                       rsp_tdata,  // [63:0] poly_value
   output logic [0:0]                        rsp_tuser,  // [0] overflow
   // degree register write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hpe_pkg::DEGREE_WIDTH-1:0]  csr_data
);
   import hpe_pkg::*;

   localparam int NUM_CELLS = MAX_DEGREE - 1;

   logic [DEGREE_WIDTH-1:0]       degree_ff, degree_clamped;
   logic                          advance;
   link_type                      head_ff, head_in;
   link_type                      link_w [0:NUM_CELLS];
   link_type                      last;
   logic                          rsp_valid_ff, rsp_ovf_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;

   // whole chain moves together unless the output is stuck
   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      if (int'(degree_ff) > MAX_DEGREE)
         degree_clamped = DEGREE_WIDTH'(MAX_DEGREE);
      else
         degree_clamped = degree_ff;
   end

   // h0 = 1.0, h1 = 2x
   always_comb begin
      head_in.valid = req_tvalid;
      head_in.ovf   = 1'b0;
      head_in.x     = $signed(req_tdata);
      head_in.p1    = VALUE_WIDTH'($signed({req_tdata, 1'b0}));
      head_in.p2    = VALUE_WIDTH'(1) <<< FRAC_BITS;
   end

   assign link_w[0] = head_ff;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      hpe_cell #(
         .STEP      (i + 2),
         .FRAC_BITS (FRAC_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .degree  (degree_clamped),
         .link_i  (link_w[i]),
         .link_o  (link_w[i+1])
      );
   end

   assign last         = link_w[NUM_CELLS];
   // degree zero returns h0, otherwise the newest term
   assign rsp_value_in = (degree_ff == '0) ? last.p2 : last.p1;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff     <= '0;
         head_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready)
            degree_ff <= csr_data;
         if (advance) begin
            head_ff      <= head_in;
            rsp_valid_ff <= last.valid;
            rsp_value_ff <= rsp_value_in;
            rsp_ovf_ff   <= last.ovf;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_value_ff;
   assign rsp_tuser[0] = rsp_ovf_ff;

   `HPE_ASSERT(a_stall_reaches_input, clock, reset,
      rsp_valid_ff && !rsp_tready |-> !req_tready)
   `HPE_ASSERT(a_head_loads, clock, reset,
      req_tvalid && req_tready |=> head_ff.valid && head_ff.p2 == (VALUE_WIDTH'(1) <<< FRAC_BITS))
   `HPE_ASSERT(a_result_from_chain, clock, reset,
      advance && last.valid |=> rsp_valid_ff && rsp_ovf_ff == $past(last.ovf))

endmodule

>>> verif/hermite_polynomial_evaluator_checker.sv
// Checker for the Hermite polynomial evaluator: watches the req_, rsp_ and csr_ channels,
// predicts H_n(x) for every request transfer and compares it with the response stream.
// Depends on hpe_pkg for field widths and the 64-bit saturation limits.
module hermite_polynomial_evaluator_checker #(
   parameter int MAX_DEGREE = 12,
   parameter int FRAC_BITS  = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [15:0]                      req_tdata,   // [15:0] sample_x
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [63:0]                      rsp_tdata,   // [63:0] poly_value
   input  logic [0:0]                       rsp_tuser,   // [0] overflow
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [hpe_pkg::DEGREE_WIDTH-1:0] csr_data,
   output int                               mismatches,
   output int                               awaited,
   output int                               results_seen,
   output int                               saturated_seen
);
   import hpe_pkg::*;

   typedef struct packed {
      logic signed [X_WIDTH-1:0]     x;
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          ovf;
   } hermite_result_type;

   hermite_result_type          pending_values[$];
   hermite_result_type          oldest;
   logic [DEGREE_WIDTH-1:0]     degree_reg;

   // Three-term recurrence in 128-bit exact arithmetic, saturating each step.
   function automatic hermite_result_type hermite_eval(logic signed [X_WIDTH-1:0] x,
                                                       logic [DEGREE_WIDTH-1:0] deg);
      hermite_result_type  r;
      int                  n;
      logic signed [127:0] h1, h2, twox, t, s, d;
      r.x   = x;
      r.ovf = 1'b0;
      n     = (int'(deg) > MAX_DEGREE) ? MAX_DEGREE : int'(deg);
      h2    = 128'(1) <<< FRAC_BITS;
      twox  = 128'(x) <<< 1;
      h1    = twox;
      if (n == 0) begin
         r.value = h2[63:0];
      end else begin
         for (int k = 2; k <= n; k++) begin
            t = (h1 * twox) >>> FRAC_BITS;
            s = h2 * 128'(2 * (k - 1));
            d = t - s;
            if (d != {{64{d[63]}}, d[63:0]}) begin
               r.ovf = 1'b1;
               d     = d[127] ? 128'(VALUE_MIN) : 128'(VALUE_MAX);
            end
            h2 = h1;
            h1 = d;
         end
         r.value = h1[63:0];
      end
      return r;
   endfunction

   task automatic note_mismatch(input string what, input hermite_result_type want);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: x=%0d expected value=%0d ovf=%0b, got value=%0d ovf=%0b",
                  what, want.x, want.value, want.ovf, $signed(rsp_tdata), rsp_tuser[0]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         degree_reg = '0;
         pending_values.delete();
         mismatches     = 0;
         results_seen   = 0;
         saturated_seen = 0;
      end else begin
         if (csr_valid && csr_ready)
            degree_reg = csr_data;
         if (req_tvalid && req_tready)
            pending_values.insert(pending_values.size(), hermite_eval(req_tdata, degree_reg));
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (rsp_tuser[0] === 1'b1)
               saturated_seen++;
            if (pending_values.size() == 0) begin
               note_mismatch("unexpected result", '0);
            end else begin
               oldest = pending_values.pop_front();
               if (rsp_tdata !== oldest.value || rsp_tuser[0] !== oldest.ovf)
                  note_mismatch("mismatch", oldest);
            end
         end
      end
      awaited = pending_values.size();
   end

endmodule

>>> verif/hermite_polynomial_evaluator_unit_test.sv
// Testbench top for the Hermite polynomial evaluator: clock, reset, stimulus and verdict.
// Depends on hpe_pkg, hermite_polynomial_evaluator_unit and hermite_polynomial_evaluator_checker.
module hermite_polynomial_evaluator_unit_test;
   import hpe_pkg::*;

   localparam int MAX_DEGREE  = 12;
   localparam int FRAC_BITS   = 12;
   localparam int LATENCY     = 2 * MAX_DEGREE;
   localparam int PHASE_ITEMS = 105;
   localparam int HOLD_CYCLES = 240;   // long receiver hold-off, fills the cell chain
   localparam int IDLE_LIMIT  = 3000;  // watchdog: cycles with no transfer on any channel

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [15:0]             req_tdata;   // [15:0] sample_x
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [63:0]             rsp_tdata;   // [63:0] poly_value
   logic [0:0]              rsp_tuser;   // [0] overflow
   logic                    csr_valid;
   logic                    csr_ready;
   logic [DEGREE_WIDTH-1:0] csr_data;

   int mismatches;
   int awaited;
   int results_seen;
   int saturated_seen;

   // Stimulus knobs shared between the sender and the receiver process.
   bit hold_request;   // sender asks the receiver for one long hold-off
   bit hold_taken;
   bit steady_tail;    // last part of the run: no idling on either side
   int gap_odds;       // sender pauses after roughly one transfer in gap_odds; 0 = never
   int points_sent;
   int idle_cycles;
   int stall_left;
   int hold_left;

   hermite_polynomial_evaluator_unit #(
      .MAX_DEGREE (MAX_DEGREE),
      .FRAC_BITS  (FRAC_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   hermite_polynomial_evaluator_checker #(
      .MAX_DEGREE (MAX_DEGREE),
      .FRAC_BITS  (FRAC_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatches     (mismatches),
      .awaited        (awaited),
      .results_seen   (results_seen),
      .saturated_seen (saturated_seen)
   );

   // 12-unit clock period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver: random stall bursts, one long hold-off on request,
   // and always ready once the steady tail starts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left  = 0;
         hold_left   = 0;
      end else begin
         if (hold_request && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0 && !steady_tail) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!steady_tail && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: a long stretch without any transfer means the block hung.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: %0d cycles without a transfer, %0d results still due",
                  idle_cycles, awaited);
         $display("FAILURE");
         $finish;
      end
   end

   // Wait until the checker holds no expectation. Sampled on the falling edge so the
   // checker's update at the rising edge has settled.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (awaited != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // The degree register is written only with the cell chain empty.
   task automatic set_degree(input logic [DEGREE_WIDTH-1:0] deg);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= deg;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // One request transfer; tvalid stays high unless a random gap is drawn, so back-to-back points stream at full rate.
   task automatic send_point(input logic [15:0] x);
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      points_sent++;
      if (!steady_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 16'($urandom);
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Mix of corner points, the small-magnitude region where the recurrence cancels
   // heavily, and the full signed 16-bit range.
   function automatic logic [15:0] pick_x();
      logic [15:0] corners [5];
      corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
      case ($urandom_range(0, 9))
         0: begin
            return corners[$urandom_range(0, 4)];
         end
         1, 2, 3: begin
            return 16'($signed($urandom_range(0, 16384)) - 8192);
         end
         default: begin
            return 16'($urandom);
         end
      endcase
   endfunction

   initial begin
      int degree_order [16];

      degree_order = '{3, 0, 12, 7, 1, 15, 5, 2, 13, 9, 4, 11, 6, 14, 8, 10};
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      hold_request = 1'b0;
      hold_taken   = 1'b0;
      steady_tail  = 1'b0;
      gap_odds     = 6;
      points_sent  = 0;
      idle_cycles  = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: degree zero ignores x, degree one is just 2x, degree two, then the
      // extremes of x at the top degree and a degree past the clamp.
      set_degree(4'd0);
      send_point(16'h0000);
      send_point(16'h8000);
      send_point(16'h7FFF);
      set_degree(4'd1);
      send_point(16'h7FFF);
      send_point(16'h8000);
      send_point(16'h0001);
      send_point(16'hFFFF);
      set_degree(4'd2);
      send_point(16'h1000);
      send_point(16'hF000);
      send_point(16'h0000);
      set_degree(4'd12);
      send_point(16'h8000);
      send_point(16'h7FFF);
      send_point(16'h0001);
      send_point(16'hFFFF);
      send_point(16'h0800);
      send_point(16'h0000);
      set_degree(4'd15);
      send_point(16'h8000);
      send_point(16'h3039);

      // Random phases, one per degree value; each starts from an empty chain.
      for (int p = 0; p < 16; p++) begin
         set_degree(DEGREE_WIDTH'(degree_order[p]));
         steady_tail = (p >= 13);
         case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 4;
            default: gap_odds = 12;
         endcase
         // Keep offering points while the receiver holds off, so the chain backs up
         // and req_tready drops.
         if (p == 2) begin
            gap_odds     = 0;
            hold_request = 1'b1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_point(pick_x());
      end

      drain();
      repeat (LATENCY + 8) @(posedge clock);

      $display("Checked %0d results for %0d sample points across every degree setting 0..15,",
               results_seen, points_sent);
      $display("including a full-chain backpressure stretch; %0d results flagged saturation.",
               saturated_seen);
      if (mismatches == 0 && awaited == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatches, awaited);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/hpe_pkg.sv
rtl/hpe_cell.sv
rtl/hermite_polynomial_evaluator_unit.sv
verif/hermite_polynomial_evaluator_checker.sv
verif/hermite_polynomial_evaluator_unit_test.sv
